### rtl/fct_pkg.sv
// Package for the fault code table: field widths, request and result codes,
// the table entry type and the controller state type. No dependencies.
package fct_pkg;

    localparam int CODE_W      = 32;
    localparam int STATUS_W    = 8;
    localparam int MASK_W      = 8;
    localparam int REQ_W       = 3;
    localparam int SES_W       = 2;
    localparam int RC_W        = 4;
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [RC_W-1:0]  t_rc;

    localparam t_req REQ_ADD     = 3'd0;
    localparam t_req REQ_SET     = 3'd1;
    localparam t_req REQ_CLEAR   = 3'd2;
    localparam t_req REQ_READ    = 3'd3;
    localparam t_req REQ_SESSION = 3'd4;

    localparam t_rc RC_ADDED     = 4'd0;
    localparam t_rc RC_FULL      = 4'd1;
    localparam t_rc RC_UNSUP     = 4'd2;
    localparam t_rc RC_EXISTS    = 4'd3;
    localparam t_rc RC_CLEARED   = 4'd4;
    localparam t_rc RC_DEFAULT   = 4'd5;
    localparam t_rc RC_MISSING   = 4'd6;
    localparam t_rc RC_SET       = 4'd7;
    localparam t_rc RC_CHANGED   = 4'd8;
    localparam t_rc RC_SAME      = 4'd9;
    localparam t_rc RC_ENTRY     = 4'd10;
    localparam t_rc RC_NONE      = 4'd11;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

endpackage

### rtl/fct_if.sv
// Valid/ready channel interfaces of the fault code table: request, response
// and configuration write. Depends on fct_pkg for the field widths.
interface fct_req_if;
    logic                          valid;
    logic                          ready;
    logic [fct_pkg::REQ_W-1:0]     req_type;
    logic [fct_pkg::CODE_W-1:0]    code;
    logic [fct_pkg::STATUS_W-1:0]  status;
    logic [fct_pkg::MASK_W-1:0]    mask;
    logic [fct_pkg::SES_W-1:0]     session;

    modport source (output valid, req_type, code, status, mask, session, input ready);
    modport sink   (input valid, req_type, code, status, mask, session, output ready);
endinterface

interface fct_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fct_pkg::RC_W-1:0]      result_code;
    logic [fct_pkg::CODE_W-1:0]    entry_code;
    logic [fct_pkg::STATUS_W-1:0]  entry_status;
    logic                          last;

    modport source (output valid, result_code, entry_code, entry_status, last, input ready);
    modport sink   (input valid, result_code, entry_code, entry_status, last, output ready);
endinterface

interface fct_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fct_pkg::STATUS_W-1:0]  supported_status;

    modport source (output valid, supported_status, input ready);
    modport sink   (input valid, supported_status, output ready);
endinterface

### rtl/fct_cell.sv
// One storage cell of the fault code table ring: holds one entry and takes
// its neighbor's entry on a shift. Depends on fct_pkg for the entry type.
module fct_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  fct_pkg::t_entry i_prev,
    output fct_pkg::t_entry o_entry
);
    import fct_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

### rtl/fault_code_table_top.sv
// Fault code table top level: ring of fct_cell entries and the request
// sequencer. Depends on fct_pkg, fct_if and fct_cell.

// The table is a ring of TABLE_DEPTH cells that, during a walk, rotates one
// place per cycle unless a stalled response holds it, past a single
// compare/update point at cell 0. Add, set-status and read-by-mask requests
// are accepted, take one full turn of the ring, close the walk and then
// deliver the final transaction; a stalled response holds the ring.
// Clear-all, set-session and requests refused up front are accepted and then
// deliver their transaction without a walk. One request is handled at a
// time; requests of an unknown type are dropped with no response. The
// supported-status register resets to all ones; the user must write it
// through the configuration channel only while no request is in progress,
// which the block itself does not enforce.
module fault_code_table_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fct_req_if.sink   i_req,
    fct_rsp_if.source o_rsp,
    fct_cfg_if.sink   i_cfg
);
    import fct_pkg::*;

    localparam int K_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [K_W-1:0]    DEPTH_K = K_W'(TABLE_DEPTH);
    localparam logic [NRES_W-1:0] MAX_N   = NRES_W'(MAX_RESULTS);

    t_state                r_state, n_state;
    t_req                  r_op;
    logic [CODE_W-1:0]     r_code;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   r_allowed;
    logic [K_W-1:0]        r_step;
    logic [K_W-1:0]        r_count;
    logic [SES_W-1:0]      r_session;
    logic [STATUS_W-1:0]   r_sup;
    logic                  r_flag;
    logic                  r_pend_v;
    t_entry                r_pend;
    logic [NRES_W-1:0]     r_nres;
    t_rc                   r_fin_rc;
    logic                  r_out_v;
    t_rc                   r_out_rc;
    t_entry                r_out_entry;
    logic                  r_out_last;

    t_entry w_cell [TABLE_DEPTH];
    t_entry w_head;
    t_entry w_tail;
    logic   w_accept;
    logic   w_unsup;
    logic   w_exam;
    logic   w_hit_code;
    logic   w_hit_read;
    logic   w_can_push;
    logic   w_walking;
    logic   w_walk_end;
    logic   w_need_push;
    logic   w_shift;
    logic   w_push;
    t_rc    w_push_rc;
    t_entry w_push_entry;
    logic   w_push_last;

    // ring of cells, cell 0 is the compare point
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == TABLE_DEPTH - 1) begin : g_tail
            fct_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_prev  (w_tail),
                .o_entry (w_cell[g])
            );
        end else begin : g_body
            fct_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_prev  (w_cell[g+1]),
                .o_entry (w_cell[g])
            );
        end
    end

    assign w_head      = w_cell[0];
    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_unsup     = |(i_req.status & ~r_sup);

    assign w_walking   = (r_state == ST_WALK) && (r_step != DEPTH_K);
    assign w_walk_end  = (r_state == ST_WALK) && (r_step == DEPTH_K);
    assign w_exam      = r_step < r_count;
    assign w_hit_code  = w_exam && (w_head.code == r_code);
    assign w_hit_read  = w_exam && (|(w_head.status & r_allowed)) && (r_nres < MAX_N);
    assign w_can_push  = !r_out_v || o_rsp.ready;
    assign w_need_push = (r_op == REQ_READ) && w_hit_read && r_pend_v;
    assign w_shift     = w_walking && (!w_need_push || w_can_push);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_ADD: begin
                            n_state = (r_count == DEPTH_K || w_unsup) ? ST_FINISH : ST_WALK;
                        end
                        REQ_SET:     n_state = w_unsup ? ST_FINISH : ST_WALK;
                        REQ_CLEAR:   n_state = ST_FINISH;
                        REQ_READ:    n_state = ST_WALK;
                        REQ_SESSION: n_state = ST_FINISH;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (w_walk_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_can_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ring write-back and response pushes
    always_comb begin
        w_tail       = w_head;
        w_push       = 1'b0;
        w_push_rc    = r_fin_rc;
        w_push_entry = '0;
        w_push_last  = 1'b1;
        case (r_state)
            ST_WALK: begin
                if (r_op == REQ_ADD && r_step == r_count && !r_flag) begin
                    w_tail = '{code: r_code, status: r_status};
                end else if (r_op == REQ_SET && w_hit_code) begin
                    w_tail = '{code: w_head.code, status: r_status};
                end
                if (w_walking && w_need_push && w_can_push) begin
                    w_push       = 1'b1;
                    w_push_rc    = RC_ENTRY;
                    w_push_entry = r_pend;
                    w_push_last  = 1'b0;
                end
            end
            ST_FINISH: begin
                w_push = w_can_push;
                if (r_fin_rc == RC_ENTRY) begin
                    w_push_entry = r_pend;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_session <= '0;
            r_sup     <= '1;
            r_out_v   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_flag    <= 1'b0;
            r_step    <= '0;
            r_nres    <= '0;
            r_op      <= REQ_ADD;
            r_fin_rc  <= RC_NONE;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                r_sup <= i_cfg.supported_status;
            end

            if (w_accept) begin
                r_op      <= i_req.req_type;
                r_code    <= i_req.code;
                r_status  <= i_req.status;
                r_allowed <= i_req.mask & r_sup;
                r_step    <= '0;
                r_flag    <= 1'b0;
                r_pend_v  <= 1'b0;
                r_nres    <= '0;
                case (i_req.req_type)
                    REQ_ADD: begin
                        if (r_count == DEPTH_K) begin
                            r_fin_rc <= RC_FULL;
                        end else if (w_unsup) begin
                            r_fin_rc <= RC_UNSUP;
                        end
                    end
                    REQ_SET: begin
                        if (w_unsup) begin
                            r_fin_rc <= RC_UNSUP;
                        end
                    end
                    REQ_CLEAR: begin
                        if (r_session == '0) begin
                            r_fin_rc <= RC_DEFAULT;
                        end else begin
                            r_fin_rc <= RC_CLEARED;
                            r_count  <= '0;
                        end
                    end
                    REQ_SESSION: begin
                        if (r_session == i_req.session) begin
                            r_fin_rc <= RC_SAME;
                        end else begin
                            r_fin_rc  <= RC_CHANGED;
                            r_session <= i_req.session;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (w_shift) begin
                r_step <= r_step + K_W'(1);
                if ((r_op == REQ_ADD || r_op == REQ_SET) && w_hit_code) begin
                    r_flag <= 1'b1;
                end
                if (r_op == REQ_READ && w_hit_read) begin
                    r_pend   <= w_head;
                    r_pend_v <= 1'b1;
                    r_nres   <= r_nres + NRES_W'(1);
                end
            end

            // decide the closing transaction after one full turn
            if (w_walk_end) begin
                case (r_op)
                    REQ_ADD: begin
                        r_fin_rc <= r_flag ? RC_EXISTS : RC_ADDED;
                        if (!r_flag) begin
                            r_count <= r_count + K_W'(1);
                        end
                    end
                    REQ_SET:  r_fin_rc <= r_flag ? RC_SET : RC_MISSING;
                    REQ_READ: r_fin_rc <= r_pend_v ? RC_ENTRY : RC_NONE;
                    default:  r_fin_rc <= RC_NONE;
                endcase
            end

            if (r_state == ST_FINISH && w_can_push) begin
                r_pend_v <= 1'b0;
            end

            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_rc    <= w_push_rc;
            r_out_entry <= w_push_entry;
            r_out_last  <= w_push_last;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.result_code  = r_out_rc;
    assign o_rsp.entry_code   = r_out_entry.code;
    assign o_rsp.entry_status = r_out_entry.status;
    assign o_rsp.last         = r_out_last;

    a_shift_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> (r_state == ST_WALK))
        else $error("ring rotated outside a walk");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_K)
        else $error("entry count beyond table depth");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= MAX_N)
        else $error("read result count beyond limit");

    a_pend_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && r_state != ST_IDLE) |-> (r_op == REQ_READ))
        else $error("pending entry held outside a read");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_v || o_rsp.ready))
        else $error("response overwritten before it was taken");

endmodule
